// ===== hw/rtl/sct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants for the source code tokenizer
// Token kind codes, scanner mode codes and the token word type.
// ----------------------------------------------------------------------------
package sct_pkg;

    localparam int POSITION_BITS_DEF   = 20;
    localparam int KEYWORD_MAX_LEN_DEF = 6;
    localparam int FIELD_BITS          = 20;
    localparam int KIND_BITS           = 6;

    localparam logic [KIND_BITS-1:0] K_BANG      = 6'd14;
    localparam logic [KIND_BITS-1:0] K_EQUAL     = 6'd16;
    localparam logic [KIND_BITS-1:0] K_LESS      = 6'd18;
    localparam logic [KIND_BITS-1:0] K_GREATER   = 6'd20;
    localparam logic [KIND_BITS-1:0] K_AMP_AMP   = 6'd22;
    localparam logic [KIND_BITS-1:0] K_PIPE_PIPE = 6'd23;
    localparam logic [KIND_BITS-1:0] K_SLASH     = 6'd24;
    localparam logic [KIND_BITS-1:0] K_STRLIT    = 6'd25;
    localparam logic [KIND_BITS-1:0] K_NUMBER    = 6'd26;
    localparam logic [KIND_BITS-1:0] K_IDENT     = 6'd27;
    localparam logic [KIND_BITS-1:0] K_KEYWORD0  = 6'd28;
    localparam logic [KIND_BITS-1:0] K_EOF       = 6'd41;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_NUMBER  = 4'd2;
    localparam logic [3:0] M_STRING  = 4'd3;
    localparam logic [3:0] M_COMMENT = 4'd4;
    localparam logic [3:0] M_BANG    = 4'd5;
    localparam logic [3:0] M_EQUAL   = 4'd6;
    localparam logic [3:0] M_LESS    = 4'd7;
    localparam logic [3:0] M_GREATER = 4'd8;
    localparam logic [3:0] M_AMP     = 4'd9;
    localparam logic [3:0] M_PIPE    = 4'd10;
    localparam logic [3:0] M_SLASH   = 4'd11;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic [FIELD_BITS-1:0] line;
        logic                  last;
    } t_token;

    function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        k = '1;
        case (c)
            8'h28: k = 6'd0;
            8'h29: k = 6'd1;
            8'h7B: k = 6'd2;
            8'h7D: k = 6'd3;
            8'h5B: k = 6'd4;
            8'h5D: k = 6'd5;
            8'h2C: k = 6'd6;
            8'h2E: k = 6'd7;
            8'h3B: k = 6'd8;
            8'h3A: k = 6'd9;
            8'h2B: k = 6'd10;
            8'h2D: k = 6'd11;
            8'h2A: k = 6'd12;
            8'h25: k = 6'd13;
            default: k = '1;
        endcase
        return k;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    // keyword table, first byte in the low byte
    function automatic logic [KIND_BITS-1:0] kw_kind(input logic [63:0] p,
                                                      input logic [3:0] n);
        logic [KIND_BITS-1:0] k;
        k = K_IDENT;
        if      (n == 4'd6 && p[47:0] == 48'h746375727473) k = 6'd28;
        else if (n == 4'd4 && p[31:0] == 32'h636e7566)     k = 6'd29;
        else if (n == 4'd3 && p[23:0] == 24'h746e69)       k = 6'd30;
        else if (n == 4'd4 && p[31:0] == 32'h6c6f6f62)     k = 6'd31;
        else if (n == 4'd6 && p[47:0] == 48'h676e69727473) k = 6'd32;
        else if (n == 4'd4 && p[31:0] == 32'h64696f76)     k = 6'd33;
        else if (n == 4'd2 && p[15:0] == 16'h6669)         k = 6'd34;
        else if (n == 4'd4 && p[31:0] == 32'h65736c65)     k = 6'd35;
        else if (n == 4'd5 && p[39:0] == 40'h656c696877)   k = 6'd36;
        else if (n == 4'd6 && p[47:0] == 48'h6e7275746572) k = 6'd37;
        else if (n == 4'd4 && p[31:0] == 32'h65757274)     k = 6'd38;
        else if (n == 4'd5 && p[39:0] == 40'h65736c6166)   k = 6'd39;
        else if (n == 4'd3 && p[23:0] == 24'h77656e)       k = 6'd40;
        return k;
    endfunction

endpackage

// ===== hw/rtl/sct_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_front: byte scanner
// Runs the lexer state machine one byte per cycle while the queue has room and
// produces up to two token words per byte into the token queue.
// ----------------------------------------------------------------------------
module sct_front #(
    parameter int POSITION_BITS   = 20,
    parameter int KEYWORD_MAX_LEN = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_char_byte,
    input  logic           i_end_of_source,
    input  logic           i_room,
    output logic           o_ready,
    output logic [1:0]     o_count,
    output sct_pkg::t_token o_tok0,
    output sct_pkg::t_token o_tok1
);
    import sct_pkg::*;

    localparam int PW = KEYWORD_MAX_LEN * 8;
    localparam int LB = $clog2(KEYWORD_MAX_LEN + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [FIELD_BITS-1:0]    F_MAX   = '1;

    logic [3:0]               r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos, r_begin, n_begin;
    logic [FIELD_BITS-1:0]    r_line, n_line;
    logic [PW-1:0]            r_pref, n_pref;
    logic [LB-1:0]            r_plen, n_plen;
    logic                     r_povf, n_povf;

    logic                     fire;
    logic [1:0]               cnt;
    t_token                   t0, t1;
    logic [POSITION_BITS-1:0] span;
    logic [63:0]              pref64;
    logic [KIND_BITS-1:0]     idk, sk, pk;

    assign o_ready = i_room;
    assign fire    = i_valid && i_room;
    assign span    = r_pos - r_begin;

    function automatic logic [FIELD_BITS-1:0] sat(input logic [POSITION_BITS:0] v);
        logic [FIELD_BITS-1:0] f;
        if (64'(v) > 64'(F_MAX)) f = F_MAX;
        else f = FIELD_BITS'(v);
        return f;
    endfunction

    always_comb begin
        pref64 = 64'(r_pref);
        idk    = r_povf ? K_IDENT : kw_kind(pref64, 4'(r_plen));
        sk     = single_kind(i_char_byte);
        pk     = (r_mode == M_BANG) ? K_BANG : (r_mode == M_EQUAL) ? K_EQUAL :
                 (r_mode == M_LESS) ? K_LESS : K_GREATER;
    end

    always_comb begin
        logic emit_pend, rescan;
        logic [KIND_BITS-1:0] pkind;
        logic [POSITION_BITS:0] plen, pstart;
        logic [7:0] c;
        c = i_char_byte;
        n_mode = r_mode; n_pos = r_pos; n_begin = r_begin; n_line = r_line;
        n_pref = r_pref; n_plen = r_plen; n_povf = r_povf;
        cnt = 2'd0; t0 = '0; t1 = '0;
        emit_pend = 1'b0; rescan = 1'b0; pkind = '0; plen = '0;
        pstart = {1'b0, r_begin};
        if (i_end_of_source) begin
            unique case (r_mode)
                M_IDENT:  begin emit_pend = 1'b1; pkind = idk; plen = {1'b0, span}; end
                M_NUMBER: begin emit_pend = 1'b1; pkind = K_NUMBER; plen = {1'b0, span}; end
                M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
                    emit_pend = 1'b1; pkind = pk; plen = (POSITION_BITS+1)'(1);
                end
                M_SLASH:  begin
                    emit_pend = 1'b1; pkind = K_SLASH; plen = (POSITION_BITS+1)'(1);
                end
                default: ;
            endcase
            t0 = '{kind: pkind, start: sat(pstart), length: sat(plen), line: r_line,
                   last: 1'b0};
            t1 = '{kind: K_EOF, start: sat({1'b0, r_pos}), length: '0, line: r_line,
                   last: 1'b1};
            if (emit_pend) begin
                cnt = 2'd2;
            end else begin
                cnt = 2'd1; t0 = t1;
            end
            n_mode = M_IDLE; n_pos = '0; n_begin = '0; n_line = FIELD_BITS'(1);
            n_pref = '0; n_plen = '0; n_povf = 1'b0;
        end else begin
            unique case (r_mode)
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        if (r_plen < LB'(KEYWORD_MAX_LEN)) begin
                            n_pref = r_pref | (PW'(c) << (8 * r_plen));
                            n_plen = r_plen + 1'b1;
                        end else n_povf = 1'b1;
                    end else begin
                        emit_pend = 1'b1; pkind = idk; plen = {1'b0, span}; rescan = 1'b1;
                    end
                end
                M_NUMBER: if (!is_digit(c)) begin
                    emit_pend = 1'b1; pkind = K_NUMBER; plen = {1'b0, span}; rescan = 1'b1;
                end
                M_STRING: begin
                    if (c == 8'h22) begin
                        emit_pend = 1'b1; pkind = K_STRLIT;
                        plen = (span != '0) ? {1'b0, span - 1'b1} : '0;
                        pstart = {1'b0, r_begin} + 1'b1;
                        n_mode = M_IDLE;
                    end else if (c == 8'h0A && r_line != F_MAX) n_line = r_line + 1'b1;
                end
                M_COMMENT: if (c == 8'h0A) rescan = 1'b1;
                M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
                    emit_pend = 1'b1;
                    if (c == 8'h3D) begin
                        pkind = pk + 1'b1; plen = (POSITION_BITS+1)'(2); n_mode = M_IDLE;
                    end else begin
                        pkind = pk; plen = (POSITION_BITS+1)'(1); rescan = 1'b1;
                    end
                end
                M_AMP: if (c == 8'h26) begin
                    emit_pend = 1'b1; pkind = K_AMP_AMP; plen = (POSITION_BITS+1)'(2);
                    n_mode = M_IDLE;
                end else rescan = 1'b1;
                M_PIPE: if (c == 8'h7C) begin
                    emit_pend = 1'b1; pkind = K_PIPE_PIPE; plen = (POSITION_BITS+1)'(2);
                    n_mode = M_IDLE;
                end else rescan = 1'b1;
                M_SLASH: if (c == 8'h2F) n_mode = M_COMMENT;
                else begin
                    emit_pend = 1'b1; pkind = K_SLASH; plen = (POSITION_BITS+1)'(1);
                    rescan = 1'b1;
                end
                default: rescan = 1'b1;
            endcase
            t0 = '{kind: pkind, start: sat(pstart), length: sat(plen), line: r_line,
                   last: 1'b1};
            if (emit_pend) cnt = 2'd1;
            if (rescan) begin
                n_mode = M_IDLE;
                if (sk != '1) begin
                    t1 = '{kind: sk, start: sat({1'b0, r_pos}), length: FIELD_BITS'(1),
                           line: r_line, last: 1'b1};
                    if (emit_pend) begin
                        t0.last = 1'b0; cnt = 2'd2;
                    end else begin
                        t0 = t1; cnt = 2'd1;
                    end
                end else begin
                    n_begin = r_pos;
                    priority case (1'b1)
                        c == 8'h21: n_mode = M_BANG;
                        c == 8'h3D: n_mode = M_EQUAL;
                        c == 8'h3C: n_mode = M_LESS;
                        c == 8'h3E: n_mode = M_GREATER;
                        c == 8'h26: n_mode = M_AMP;
                        c == 8'h7C: n_mode = M_PIPE;
                        c == 8'h2F: n_mode = M_SLASH;
                        c == 8'h22: n_mode = M_STRING;
                        c == 8'h0A: if (r_line != F_MAX) n_line = r_line + 1'b1;
                        is_digit(c): n_mode = M_NUMBER;
                        is_alpha(c): begin
                            n_mode = M_IDENT; n_pref = PW'(c);
                            n_plen = LB'(1); n_povf = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            if (r_pos != POS_MAX) n_pos = r_pos + 1'b1;
        end
    end

    assign o_count = fire ? cnt : 2'd0;
    assign o_tok0  = t0;
    assign o_tok1  = t1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE; r_pos <= '0; r_begin <= '0; r_line <= FIELD_BITS'(1);
            r_pref <= '0; r_plen <= '0; r_povf <= 1'b0;
        end else if (fire) begin
            r_mode <= n_mode; r_pos <= n_pos; r_begin <= n_begin; r_line <= n_line;
            r_pref <= n_pref; r_plen <= n_plen; r_povf <= n_povf;
        end
    end

    a_line_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0) else $error("line counter zero");
    a_plen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_plen <= LB'(KEYWORD_MAX_LEN)) else $error("prefix length overflow");
    a_eof_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && i_end_of_source |=> r_mode == M_IDLE && r_pos == '0)
        else $error("end did not reset scanner");
    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= M_SLASH) else $error("bad mode");
    a_line_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_line)) else $error("line moved without byte");
endmodule

// ===== hw/rtl/sct_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sct_queue: token queue
// Four-entry queue taking up to two token words a cycle, giving one when the reader is ready.
// ----------------------------------------------------------------------------
module sct_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_count,
    input  sct_pkg::t_token i_tok0,
    input  sct_pkg::t_token i_tok1,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output sct_pkg::t_token o_tok
);
    import sct_pkg::*;

    t_token     r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    assign o_valid = r_cnt != 3'd0;
    assign pop     = o_valid && i_ready;
    assign o_room  = r_cnt <= 3'd2;
    assign o_tok   = r_mem[r_rp];
    assign n_cnt   = r_cnt + 3'(i_count) - 3'(pop);

    always_ff @(posedge i_clk) begin
        if (i_count != 2'd0) r_mem[r_wp] <= i_tok0;
        if (i_count == 2'd2) r_mem[r_wp + 2'd1] <= i_tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + i_count;
            r_rp  <= r_rp + 2'(pop);
            r_cnt <= n_cnt;
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue overflow");
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_room |-> i_count == 2'd0) else $error("write without room");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> r_wp == r_rp) else $error("pointer mismatch");
endmodule

// ===== hw/rtl/source_code_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_code_tokenizer: streaming lexer, one byte per cycle while the queue has room
// Output: a completed token is written into the token queue and offered from its head.
// Throughput: one byte per cycle while at least two of the four token queue
// entries are free; the queue drains at one token per cycle while i_ready is high.
// Reset: synchronous active low; scanner idle, offset 0, line 1, queue empty.
// ----------------------------------------------------------------------------
module source_code_tokenizer #(
    parameter int POSITION_BITS   = sct_pkg::POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = sct_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_source,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [19:0] o_token_start,
    output logic [19:0] o_token_length,
    output logic [19:0] o_token_line,
    output logic        o_last_of_run
);
    import sct_pkg::*;

    logic   room;
    logic [1:0] count;
    t_token tok0, tok1, otok;

    sct_front #(.POSITION_BITS(POSITION_BITS), .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_char_byte, .i_end_of_source,
        .i_room(room), .o_ready, .o_count(count), .o_tok0(tok0), .o_tok1(tok1)
    );

    sct_queue u_queue (
        .i_clk, .i_rst_n, .i_count(count), .i_tok0(tok0), .i_tok1(tok1),
        .o_room(room), .o_valid, .i_ready, .o_tok(otok)
    );

    assign o_token_kind   = otok.kind;
    assign o_token_start  = otok.start;
    assign o_token_length = otok.length;
    assign o_token_line   = otok.line;
    assign o_last_of_run  = otok.last;
endmodule
